[rtl/core/pls_pkg.sv]
// Shared types and codes for the positional list store.
// Used by pls_ctrl, pls_datapath and positional_list_store; no dependencies.
package pls_pkg;

    localparam int DEFAULT_MAX_ENTRIES = 64;

    // operation codes
    localparam logic [2:0] MODE_APPEND = 3'd0;
    localparam logic [2:0] MODE_INSERT = 3'd1;
    localparam logic [2:0] MODE_DELETE = 3'd2;
    localparam logic [2:0] MODE_CLEAR  = 3'd3;
    localparam logic [2:0] MODE_READ   = 3'd4;
    localparam logic [2:0] MODE_WRITE  = 3'd5;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] value;
        logic [6:0]         position;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [6:0]         entries_used;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch the accepted input beat
        logic decode;    // check ranges, do the work that needs no shift or read
        logic wr_shift;  // move one entry during insert/delete
        logic place;     // write the inserted value at its position
        logic capture;   // take read data as the result
        logic push;      // load the output register
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic go_shift;     // decode needs a shift sequence
        logic go_read;      // decode issued a memory read
        logic shift_place;  // insert shift finished, place value next
        logic shift_done;   // delete shift finished
        logic out_free;     // output register can take a beat
    } t_ctl_stat;

endpackage

[rtl/core/pls_ctrl.sv]
// Sequencing state machine for the positional list store.
// Depends on pls_pkg for the command and status structs.
module pls_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pls_pkg::t_ctl_stat  i_stat,
    output pls_pkg::t_ctl_cmd   o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DECODE   = 7'b0000010,
        S_SHIFT_RD = 7'b0000100,
        S_SHIFT_WR = 7'b0001000,
        S_PLACE    = 7'b0010000,
        S_READ     = 7'b0100000,
        S_RESP     = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                if (i_stat.go_shift) begin
                    n_state = S_SHIFT_RD;
                end else if (i_stat.go_read) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_SHIFT_RD: begin
                // memory read in flight
                n_state = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                if (i_stat.shift_place) begin
                    n_state = S_PLACE;
                end else if (i_stat.shift_done) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_SHIFT_RD;
                end
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = S_RESP;
            end
            S_READ: begin
                o_cmd.capture = 1'b1;
                n_state       = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_DECODE))
        else $error("accepted beat not decoded");

    a_place_after_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PLACE) |-> ($past(r_state) == S_SHIFT_WR))
        else $error("place without preceding shift");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");

endmodule

[rtl/core/pls_datapath.sv]
// Entry memory, entry count, cursor and output register of the list store.
// Depends on pls_pkg; driven by pls_ctrl commands.
module pls_datapath #(
    parameter int MaxEntries = pls_pkg::DEFAULT_MAX_ENTRIES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pls_pkg::t_in_item   i_in_data,
    input  pls_pkg::t_ctl_cmd   i_cmd,
    output pls_pkg::t_ctl_stat  o_stat,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output pls_pkg::t_out_item  o_out_data
);

    localparam int IW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
    localparam int CW = $clog2(MaxEntries + 1);
    localparam int PW = (CW > 7) ? CW : 7;

    logic [31:0]        r_mem [MaxEntries];
    logic [31:0]        r_rd_data;

    logic [2:0]         r_mode;
    logic [31:0]        r_value;
    logic [6:0]         r_pos;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [IW-1:0]      r_cursor;
    logic [IW-1:0]      n_cursor;
    logic [31:0]        r_res_rd;
    logic [1:0]         r_status;
    logic               r_out_valid;
    pls_pkg::t_out_item r_out;

    logic [PW-1:0]      pos_ext;
    logic [PW-1:0]      cnt_ext;
    logic [IW-1:0]      pos_idx;
    logic [IW-1:0]      cnt_idx;
    logic [IW-1:0]      cur_m1;
    logic [IW-1:0]      cur_p1;
    logic               is_full;

    logic [1:0]         dec_status;
    logic               dec_we;
    logic [IW-1:0]      dec_wa;
    logic               dec_inc;
    logic               dec_dec;
    logic               dec_clear;
    logic               dec_shift;
    logic               dec_read;

    logic               mem_we;
    logic [IW-1:0]      mem_wa;
    logic [31:0]        mem_wd;
    logic [IW-1:0]      rd_addr;

    assign pos_ext = PW'(r_pos);
    assign cnt_ext = PW'(r_count);
    assign pos_idx = IW'(r_pos);
    assign cnt_idx = IW'(r_count);
    assign cur_m1  = r_cursor - IW'(1);
    assign cur_p1  = r_cursor + IW'(1);
    assign is_full = (r_count == CW'(MaxEntries));

    // range and capacity checks on the latched beat
    always_comb begin
        dec_status = pls_pkg::ST_DONE;
        dec_we     = 1'b0;
        dec_wa     = cnt_idx;
        dec_inc    = 1'b0;
        dec_dec    = 1'b0;
        dec_clear  = 1'b0;
        dec_shift  = 1'b0;
        dec_read   = 1'b0;
        case (r_mode)
            pls_pkg::MODE_APPEND: begin
                if (is_full) begin
                    dec_status = pls_pkg::ST_FULL;
                end else begin
                    dec_we  = 1'b1;
                    dec_inc = 1'b1;
                end
            end
            pls_pkg::MODE_INSERT: begin
                if (pos_ext > cnt_ext) begin
                    dec_status = pls_pkg::ST_RANGE;
                end else if (is_full) begin
                    dec_status = pls_pkg::ST_FULL;
                end else if (pos_ext == cnt_ext) begin
                    dec_we  = 1'b1;
                    dec_inc = 1'b1;
                end else begin
                    dec_shift = 1'b1;
                end
            end
            pls_pkg::MODE_DELETE: begin
                if (pos_ext >= cnt_ext) begin
                    dec_status = pls_pkg::ST_RANGE;
                end else if (pos_ext + PW'(1) == cnt_ext) begin
                    dec_dec = 1'b1;
                end else begin
                    dec_shift = 1'b1;
                end
            end
            pls_pkg::MODE_CLEAR: begin
                dec_clear = 1'b1;
            end
            pls_pkg::MODE_READ: begin
                if (pos_ext >= cnt_ext) begin
                    dec_status = pls_pkg::ST_RANGE;
                end else begin
                    dec_read = 1'b1;
                end
            end
            pls_pkg::MODE_WRITE: begin
                if (pos_ext >= cnt_ext) begin
                    dec_status = pls_pkg::ST_RANGE;
                end else begin
                    dec_we = 1'b1;
                    dec_wa = pos_idx;
                end
            end
            default: begin
                dec_status = pls_pkg::ST_DONE;
            end
        endcase
    end

    // insert walks the cursor down from the top, delete walks it up
    assign rd_addr = (r_mode == pls_pkg::MODE_READ)   ? pos_idx :
                     (r_mode == pls_pkg::MODE_INSERT) ? cur_m1  : cur_p1;

    assign o_stat.go_shift    = dec_shift;
    assign o_stat.go_read     = dec_read;
    assign o_stat.shift_place = (r_mode == pls_pkg::MODE_INSERT) && (cur_m1 == pos_idx);
    assign o_stat.shift_done  = (r_mode == pls_pkg::MODE_DELETE)
                                && (CW'(r_cursor) + CW'(2) == r_count);
    assign o_stat.out_free    = !r_out_valid || !i_out_stall;

    assign mem_we = (i_cmd.decode && dec_we) || i_cmd.wr_shift || i_cmd.place;
    assign mem_wa = i_cmd.decode   ? dec_wa   :
                    i_cmd.wr_shift ? r_cursor : pos_idx;
    assign mem_wd = i_cmd.wr_shift ? r_rd_data : r_value;

    always_comb begin
        n_count = r_count;
        if (i_cmd.decode) begin
            if (dec_inc) begin
                n_count = r_count + CW'(1);
            end else if (dec_dec) begin
                n_count = r_count - CW'(1);
            end else if (dec_clear) begin
                n_count = '0;
            end
        end else if (i_cmd.wr_shift && o_stat.shift_done) begin
            n_count = r_count - CW'(1);
        end else if (i_cmd.place) begin
            n_count = r_count + CW'(1);
        end
    end

    always_comb begin
        n_cursor = r_cursor;
        if (i_cmd.decode) begin
            n_cursor = (r_mode == pls_pkg::MODE_INSERT) ? cnt_idx : pos_idx;
        end else if (i_cmd.wr_shift) begin
            n_cursor = (r_mode == pls_pkg::MODE_INSERT) ? cur_m1 : cur_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_in_data.mode;
            r_value <= i_in_data.value;
            r_pos   <= i_in_data.position;
        end
        r_cursor <= n_cursor;
        if (i_cmd.decode) begin
            r_status <= dec_status;
            r_res_rd <= '0;
        end else if (i_cmd.capture) begin
            r_res_rd <= r_rd_data;
        end
        if (i_cmd.push) begin
            r_out.read_value   <= r_res_rd;
            r_out.status       <= r_status;
            r_out.entries_used <= 7'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MaxEntries))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> (r_count == $past(r_count) + CW'(1)
            || r_count == $past(r_count) - CW'(1) || r_count == '0))
        else $error("entry count jumped");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push && r_status == pls_pkg::ST_FULL) |-> is_full)
        else $error("full status on a list with room");

endmodule

[rtl/core/positional_list_store.sv]
// Positional list store: one operation per input beat, one result beat each.
// Append, insert at the end, clear, write, unused modes and failed ops finish in decode;
// read adds a memory read; other inserts, and deletes of any but the last entry, move
// entries one at a time (read, then write), and an insert then places its value. The
// result waits while the output register is full and stalled. The next beat is taken
// the cycle after the result enters the output register. Sync active-low reset empties the list.
module positional_list_store #(
    parameter int MaxEntries = pls_pkg::DEFAULT_MAX_ENTRIES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pls_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pls_pkg::t_out_item  o_out_data
);

    pls_pkg::t_ctl_cmd  ctl_cmd;
    pls_pkg::t_ctl_stat ctl_stat;

    pls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (ctl_stat),
        .o_cmd      (ctl_cmd)
    );

    pls_datapath #(
        .MaxEntries (MaxEntries)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (ctl_cmd),
        .o_stat      (ctl_stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
